### rtl/rfb_pkg.sv
package rfb_pkg;

   // field widths fixed by the interface
   localparam int BYTE_W = 8;
   localparam int FLEN_W = 7;
   localparam int REQ_W  = 3;
   localparam int STAT_W = 2;

   // request kinds
   localparam logic [REQ_W-1:0] REQ_RECV    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_POP_OLD = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_NEW = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DROP    = 3'd4;

   // buffer status codes
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd0;
   localparam logic [STAT_W-1:0] ST_RECEIVING = 2'd1;
   localparam logic [STAT_W-1:0] ST_READY     = 2'd2;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;   // take the upper neighbor's byte (ring rotate)
      logic load;    // capture the received byte
   } rfb_cell_ctl_type;

endpackage

### rtl/rx_frame_buffer.sv
// rx_frame_buffer: collects received bytes into frames and hands frames back.
// req channel: tuser carries the request kind (receive, pop oldest, pop
// newest, clear, drop partial), tdata the received byte. One request is
// worked on at a time; req_tready is high only while the sequencer is idle.
// rsp channel: one transfer per frame byte (tlast on the final one), or one
// no-data transfer (tuser high) for every other request or an empty pop.
// csr channel: writes frame_length (0 selects zero-terminated framing); it
// is always ready; the user must write it only while the block is idle, and the block itself does not enforce this.
// Receive, clear, drop, unknown and refused requests are answered by one
// no-data transfer. A pop works on the byte store, a ring of BUF_DEPTH cells
// that rotates one place per cycle past cell 0, where the bytes are read,
// unless a byte waits for the output register. A fixed-length pop oldest
// rotates the frame out, a pop newest rotates once around, and a string pop
// oldest first rotates once around to find the terminator, then rotates the
// frame and its terminator out. Frame bytes leave through a one-entry
// output register; while the receiver holds rsp_tready low the ring stops at
// the next byte to send and nothing is lost. Reset clears counters and status;
// store contents stay as they were and are never read before being written.
module rx_frame_buffer
   import rfb_pkg::*;
#(
   parameter int BUF_DEPTH = 64
)
(
   input  logic              clock,
   input  logic              reset,
   // configuration: frame_length
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [FLEN_W-1:0] csr_data,
   // requests
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] rx_data
   input  logic [2:0]        req_tuser,   // [2:0] req_type
   // results
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // [7:0] data_byte, [9:8] buffer_status
   output logic              rsp_tlast,   // last_byte
   output logic [0:0]        rsp_tuser    // [0] no_data
);

   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam int IW = $clog2(BUF_DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_NONE = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_OSTR = 3'd4;
   localparam logic [2:0] S_RUN  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [REQ_W-1:0]  req_type_ff, req_type_in;
   logic [BYTE_W-1:0] rx_data_ff, rx_data_in;
   logic [FLEN_W-1:0] flen_ff, flen_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     nfs_ff, nfs_in;
   logic [CW-1:0]     part_ff, part_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [CW-1:0]     run_start_ff, run_start_in;
   logic [CW-1:0]     run_lim_ff, run_lim_in;
   logic [CW-1:0]     run_rot_ff, run_rot_in;
   logic              run_str_ff, run_str_in;
   logic              run_hit_ff, run_hit_in;
   logic              run_alive_ff, run_alive_in;
   logic [CW-1:0]     run_nfs_ff, run_nfs_in;
   logic              zfound_ff, zfound_in;
   logic [CW-1:0]     zpos_ff, zpos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_nodata_ff, rsp_nodata_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic              cell_shift, cell_load, rsp_load, slot_free;
   logic [BYTE_W-1:0] cell_bytes [BUF_DEPTH];
   logic [BYTE_W-1:0] cell0, cell1;

   // scratch values of the sequencer
   logic [CW-1:0]     pop_n, pop_rm, new_fill, nw_start, nfs_cand, step_nx;
   logic [FLEN_W:0]   nw_sum;
   logic              in_range, emit, advance, last;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign cell0      = cell_bytes[0];
   assign cell1      = cell_bytes[1];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign step_nx    = step_ff + CW'(1);

   // ring of byte cells; cell i takes cell i+1 on a rotate
   for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
      rfb_cell_ctl_type ctl;
      assign ctl.shift = cell_shift;
      assign ctl.load  = cell_load && (fill_ff[IW-1:0] == IW'(i));
      rfb_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_byte (rx_data_ff),
         .next_byte (cell_bytes[(i + 1) % BUF_DEPTH]),
         .cell_byte (cell_bytes[i])
      );
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      rx_data_in    = rx_data_ff;
      flen_in       = flen_ff;
      fill_in       = fill_ff;
      nfs_in        = nfs_ff;
      part_in       = part_ff;
      status_in     = status_ff;
      step_in       = step_ff;
      run_start_in  = run_start_ff;
      run_lim_in    = run_lim_ff;
      run_rot_in    = run_rot_ff;
      run_str_in    = run_str_ff;
      run_hit_in    = run_hit_ff;
      run_alive_in  = run_alive_ff;
      run_nfs_in    = run_nfs_ff;
      zfound_in     = zfound_ff;
      zpos_in       = zpos_ff;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_nodata_in = rsp_nodata_ff;
      rsp_status_in = rsp_status_ff;
      cell_shift    = 1'b0;
      cell_load     = 1'b0;
      pop_n         = '0;
      pop_rm        = '0;
      new_fill      = '0;
      nw_start      = '0;
      nw_sum        = '0;
      nfs_cand      = run_nfs_ff;
      in_range      = 1'b0;
      emit          = 1'b0;
      advance       = 1'b0;
      last          = 1'b0;

      if (csr_valid) begin
         flen_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_type_in = req_tuser;
               rx_data_in  = req_tdata;
               state_in    = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_NONE;
            unique case (req_type_ff)
               REQ_RECV: begin
                  if (status_ff != ST_OVERFLOW) begin
                     if (fill_ff == CW'(BUF_DEPTH)) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        cell_load = 1'b1;
                        fill_in   = fill_ff + CW'(1);
                        part_in   = part_ff + CW'(1);
                        status_in = ST_RECEIVING;
                        if ((flen_ff == '0 && rx_data_ff == '0) ||
                            (flen_ff != '0 && FLEN_W'(part_in) >= flen_ff)) begin
                           status_in = ST_READY;
                           nfs_in    = fill_ff - part_ff;
                           part_in   = '0;
                        end
                     end
                  end
               end
               REQ_CLEAR: begin
                  fill_in   = '0;
                  nfs_in    = '0;
                  part_in   = '0;
                  status_in = ST_EMPTY;
               end
               REQ_DROP: begin
                  new_fill  = (fill_ff > part_ff) ? fill_ff - part_ff : '0;
                  fill_in   = new_fill;
                  part_in   = '0;
                  status_in = (new_fill != '0) ? ST_READY : ST_EMPTY;
               end
               REQ_POP_OLD: begin
                  if (status_ff == ST_READY && fill_ff != '0) begin
                     step_in      = '0;
                     run_hit_in   = 1'b0;
                     run_alive_in = 1'b1;
                     if (flen_ff != '0) begin
                        // fixed frame: length known, rotate it out
                        pop_n        = (flen_ff < FLEN_W'(fill_ff)) ? CW'(flen_ff) : fill_ff;
                        new_fill     = fill_ff - pop_n;
                        fill_in      = new_fill;
                        nfs_in       = (FLEN_W'(nfs_ff) > flen_ff) ?
                                       CW'(FLEN_W'(nfs_ff) - flen_ff) : '0;
                        status_in    = (new_fill != '0) ? ST_READY : ST_EMPTY;
                        run_start_in = '0;
                        run_lim_in   = pop_n;
                        run_rot_in   = pop_n;
                        run_str_in   = 1'b0;
                        state_in     = S_RUN;
                     end else begin
                        // string frame: look for the terminator first
                        zfound_in = 1'b0;
                        state_in  = S_SCAN;
                     end
                  end
               end
               REQ_POP_NEW: begin
                  if (status_ff == ST_READY && fill_ff != '0) begin
                     nw_start     = (nfs_ff < fill_ff) ? nfs_ff : fill_ff;
                     fill_in      = nw_start;
                     status_in    = (nw_start != '0) ? ST_READY : ST_EMPTY;
                     step_in      = '0;
                     run_hit_in   = 1'b0;
                     run_alive_in = 1'b1;
                     run_nfs_in   = '0;
                     run_start_in = nw_start;
                     run_rot_in   = CW'(BUF_DEPTH);
                     if (flen_ff != '0) begin
                        nw_sum     = (FLEN_W+1)'(nw_start) + (FLEN_W+1)'(flen_ff);
                        run_lim_in = (nw_sum < (FLEN_W+1)'(fill_ff)) ? CW'(nw_sum) : fill_ff;
                        nfs_in     = (FLEN_W'(nw_start) > flen_ff) ?
                                     CW'(FLEN_W'(nw_start) - flen_ff) : '0;
                        run_str_in = 1'b0;
                     end else begin
                        run_lim_in = fill_ff;
                        run_str_in = 1'b1;
                     end
                     state_in = S_RUN;
                  end
               end
               default: begin
                  // unknown request: state unchanged
               end
            endcase
         end

         S_NONE: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_nodata_in = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         S_SCAN: begin
            // one full turn of the ring, noting the first zero byte
            cell_shift = 1'b1;
            if (!zfound_ff && step_ff < fill_ff && cell0 == '0) begin
               zfound_in = 1'b1;
               zpos_in   = step_ff;
            end
            if (step_ff == CW'(BUF_DEPTH - 1)) begin
               state_in = S_OSTR;
            end else begin
               step_in = step_nx;
            end
         end

         S_OSTR: begin
            pop_n        = zfound_ff ? zpos_ff : fill_ff;
            pop_rm       = zfound_ff ? zpos_ff + CW'(1) : fill_ff;
            new_fill     = fill_ff - pop_rm;
            fill_in      = new_fill;
            nfs_in       = (nfs_ff > pop_rm) ? nfs_ff - pop_rm : '0;
            status_in    = (new_fill != '0) ? ST_READY : ST_EMPTY;
            run_start_in = '0;
            run_lim_in   = pop_n;
            run_rot_in   = pop_rm;
            run_str_in   = 1'b0;
            step_in      = '0;
            state_in     = S_RUN;
         end

         S_RUN: begin
            // cell 0 holds the byte at position step_ff
            in_range = (step_ff >= run_start_ff) && (step_ff < run_lim_ff);
            emit     = in_range && run_alive_ff && !(run_str_ff && cell0 == '0);
            last     = (step_nx == run_lim_ff) || (run_str_ff && cell1 == '0);
            advance  = !emit || slot_free;
            if (run_str_ff && cell0 == '0 && step_nx < run_start_ff) begin
               nfs_cand = step_nx;
            end
            if (advance) begin
               cell_shift = 1'b1;
               run_nfs_in = nfs_cand;
               if (run_str_ff && in_range && cell0 == '0) begin
                  run_alive_in = 1'b0;
               end
               if (emit) begin
                  rsp_load      = 1'b1;
                  rsp_data_in   = cell0;
                  rsp_last_in   = last;
                  rsp_nodata_in = 1'b0;
                  rsp_status_in = status_ff;
                  run_hit_in    = 1'b1;
               end
               if (step_nx == run_rot_ff) begin
                  if (run_str_ff) begin
                     nfs_in = nfs_cand;
                  end
                  state_in = (run_hit_ff || emit) ? S_IDLE : S_NONE;
               end else begin
                  step_in = step_nx;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // output register
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         flen_ff      <= '0;
         fill_ff      <= '0;
         nfs_ff       <= '0;
         part_ff      <= '0;
         status_ff    <= ST_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flen_ff      <= flen_in;
         fill_ff      <= fill_in;
         nfs_ff       <= nfs_in;
         part_ff      <= part_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      rx_data_ff    <= rx_data_in;
      step_ff       <= step_in;
      run_start_ff  <= run_start_in;
      run_lim_ff    <= run_lim_in;
      run_rot_ff    <= run_rot_in;
      run_str_ff    <= run_str_in;
      run_hit_ff    <= run_hit_in;
      run_alive_ff  <= run_alive_in;
      run_nfs_ff    <= run_nfs_in;
      zfound_ff     <= zfound_in;
      zpos_ff       <= zpos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_nodata_ff <= rsp_nodata_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_nodata_ff;

endmodule

### rtl/rfb_cell.sv
module rfb_cell
   import rfb_pkg::*;
(
   input  logic                clock,
   input  rfb_cell_ctl_type    ctl,
   input  logic [BYTE_W-1:0]   load_byte,
   input  logic [BYTE_W-1:0]   next_byte,
   output logic [BYTE_W-1:0]   cell_byte
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   // rotate has priority; a load never coincides with it
   always_comb begin
      byte_in = byte_ff;
      if (ctl.shift) begin
         byte_in = next_byte;
      end else if (ctl.load) begin
         byte_in = load_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

### bench/tb_rx_frame_buffer.sv
module tb_rx_frame_buffer;
   import rfb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH    = 64;
   localparam int WATCHDOG = 3000;
   // highest request kind that the 3-bit field can carry
   localparam logic [REQ_W-1:0] REQ_TOP = 3'd7;

   // one result transfer, as the predictor expects it
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
      logic              no_data;
      logic [STAT_W-1:0] buffer_status;
   } frame_rsp_type;

   // Mirror of the frame store: tracks counters and bytes, and queues the
   // transfers each accepted request must produce.
   class frame_buffer_mirror_type;
      logic [BYTE_W-1:0] cells[DEPTH];
      int                fill, newest, partial, flen, faults;
      logic [STAT_W-1:0] stat;
      frame_rsp_type     owed[$];

      function new();
         fill = 0;
         newest = 0;
         partial = 0;
         flen = 0;
         faults = 0;
         stat = ST_EMPTY;
      endfunction

      function void set_length(int v);
         flen = v;
      endfunction

      function void owe_none();
         owed.push_back('{data_byte: '0, last_byte: 1'b1, no_data: 1'b1,
                          buffer_status: stat});
      endfunction

      function void take_request(logic [REQ_W-1:0] kind, logic [BYTE_W-1:0] rx);
         logic [BYTE_W-1:0] run[$];
         int                removed, start, i, k;
         case (kind)
            REQ_RECV: begin
               if (stat != ST_OVERFLOW) begin
                  if (fill >= DEPTH) begin
                     stat = ST_OVERFLOW;
                  end else begin
                     cells[fill] = rx;
                     fill++;
                     partial++;
                     stat = ST_RECEIVING;
                     if ((flen == 0 && rx == 0) || (flen > 0 && partial >= flen)) begin
                        stat = ST_READY;
                        newest = fill - partial;
                        partial = 0;
                     end
                  end
               end
               owe_none();
            end
            REQ_CLEAR: begin
               fill = 0;
               newest = 0;
               partial = 0;
               stat = ST_EMPTY;
               owe_none();
            end
            REQ_DROP: begin
               fill = (fill > partial) ? fill - partial : 0;
               partial = 0;
               stat = (fill > 0) ? ST_READY : ST_EMPTY;
               owe_none();
            end
            REQ_POP_OLD, REQ_POP_NEW: begin
               if (stat != ST_READY || fill == 0) begin
                  owe_none();
               end else begin
                  if (kind == REQ_POP_OLD) begin
                     if (flen > 0) begin
                        removed = (flen < fill) ? flen : fill;
                        for (i = 0; i < removed; i++) run.push_back(cells[i]);
                        newest = (newest > flen) ? newest - flen : 0;
                     end else begin
                        while (run.size() < fill && cells[run.size()] != 0)
                           run.push_back(cells[run.size()]);
                        // the terminator goes with the frame
                        removed = (run.size() < fill) ? run.size() + 1 : run.size();
                        newest = (newest > removed) ? newest - removed : 0;
                     end
                     for (i = 0; i + removed < fill; i++) cells[i] = cells[i + removed];
                     fill -= removed;
                  end else begin
                     start = (newest < fill) ? newest : fill;
                     if (flen > 0) begin
                        while (run.size() < flen && start + run.size() < fill)
                           run.push_back(cells[start + run.size()]);
                        newest = (start > flen) ? start - flen : 0;
                     end else begin
                        while (start + run.size() < fill && cells[start + run.size()] != 0)
                           run.push_back(cells[start + run.size()]);
                        // new newest frame begins after the previous terminator
                        newest = 0;
                        for (k = start; k >= 2; k--) begin
                           if (cells[k - 2] == 0) begin
                              newest = k - 1;
                              break;
                           end
                        end
                     end
                     fill = start;
                  end
                  stat = (fill > 0) ? ST_READY : ST_EMPTY;
                  if (run.size() == 0) begin
                     owe_none();
                  end else begin
                     foreach (run[j])
                        owed.push_back('{data_byte: run[j],
                                         last_byte: (j == run.size() - 1),
                                         no_data: 1'b0, buffer_status: stat});
                  end
               end
            end
            default: owe_none();
         endcase
      endfunction

      function void match_rsp(frame_rsp_type got);
         frame_rsp_type want;
         if (owed.size() == 0) begin
            faults++;
            $display("%0t: rsp transfer with nothing pending: expected none, actual %p",
                     $time, got);
            return;
         end
         want = owed.pop_front();
         if (got.data_byte !== want.data_byte) begin
            faults++;
            $display("%0t: data_byte expected %h actual %h", $time,
                     want.data_byte, got.data_byte);
         end
         if (got.last_byte !== want.last_byte) begin
            faults++;
            $display("%0t: last_byte expected %b actual %b", $time,
                     want.last_byte, got.last_byte);
         end
         if (got.no_data !== want.no_data) begin
            faults++;
            $display("%0t: no_data expected %b actual %b", $time,
                     want.no_data, got.no_data);
         end
         if (got.buffer_status !== want.buffer_status) begin
            faults++;
            $display("%0t: buffer_status expected %0d actual %0d", $time,
                     want.buffer_status, got.buffer_status);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [FLEN_W-1:0] csr_data = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;   // [7:0] rx_data
   logic [2:0]        req_tuser = '0;   // [2:0] req_type
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;        // [7:0] data_byte, [9:8] buffer_status
   logic              rsp_tlast;
   logic [0:0]        rsp_tuser;        // [0] no_data

   frame_buffer_mirror_type mirror = new();
   bit                      idle_on = 1'b1;
   int                      stall_left = 0;
   int                      quiet_cycles = 0;
   int                      random_sent = 0;

   rx_frame_buffer #(.BUF_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall bursts on rsp_tready
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.match_rsp('{data_byte: rsp_tdata[7:0], last_byte: rsp_tlast,
                            no_data: rsp_tuser[0], buffer_status: rsp_tdata[9:8]});
   end

   // watchdog: cycles without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [7:0] rx);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mirror.take_request(kind, rx);
   endtask

   // hold off requests until every pending result has come and the block
   // has finished its last pass over the store
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (mirror.owed.size() != 0) @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);
   endtask

   task automatic set_frame_length(input int v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= FLEN_W'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mirror.set_length(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one framing setting, then mostly well-formed frames with random pops
   task automatic run_phase(input int items);
      int flen, k, n, op;
      case ($urandom_range(0, 5))
         0, 1:    flen = 0;
         2:       flen = $urandom_range(1, 3);
         3:       flen = $urandom_range(4, 8);
         4:       flen = $urandom_range(0, DEPTH);
         default: flen = 1;
      endcase
      set_frame_length(flen);
      n = 0;
      while (n < items) begin
         op = $urandom_range(0, 9);
         if (op < 5) begin
            if (flen == 0) begin
               k = $urandom_range(0, 5);
               repeat (k) send_request(REQ_RECV, BYTE_W'($urandom_range(1, 255)));
               send_request(REQ_RECV, 8'h00);
               n += k + 1;
            end else begin
               repeat (flen) send_request(REQ_RECV, BYTE_W'($urandom_range(0, 255)));
               n += flen;
            end
         end else if (op < 8) begin
            send_request($urandom_range(0, 1) ? REQ_POP_OLD : REQ_POP_NEW,
                         BYTE_W'($urandom_range(0, 255)));
            n++;
         end else if (op == 8) begin
            send_request(REQ_W'($urandom_range(0, REQ_TOP)),
                         BYTE_W'($urandom_range(0, 255)));
            n++;
         end else begin
            // a broken frame, then discard it
            k = $urandom_range(1, 3);
            repeat (k) send_request(REQ_RECV, BYTE_W'($urandom_range(0, 255)));
            send_request(($urandom_range(0, 3) == 0) ? REQ_CLEAR : REQ_DROP,
                         BYTE_W'($urandom_range(0, 255)));
            n += k + 1;
         end
      end
      random_sent += n;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // string framing: two frames, newest then oldest, then the odd cases
      set_frame_length(0);
      send_request(REQ_RECV, 8'h41);
      send_request(REQ_RECV, 8'hFF);
      send_request(REQ_RECV, 8'h00);
      send_request(REQ_RECV, 8'h80);
      send_request(REQ_RECV, 8'h00);
      send_request(REQ_POP_NEW, 8'h00);
      send_request(REQ_POP_OLD, 8'hFF);
      send_request(REQ_POP_OLD, 8'h00);   // empty store: refused
      send_request(REQ_RECV, 8'h00);      // frame with no bytes
      send_request(REQ_POP_NEW, 8'h00);
      send_request(REQ_RECV, 8'h12);
      send_request(REQ_POP_OLD, 8'h00);   // still receiving: refused
      send_request(REQ_DROP, 8'h00);
      send_request(REQ_RECV, 8'h01);
      send_request(REQ_RECV, 8'h00);
      send_request(REQ_RECV, 8'h55);
      send_request(REQ_CLEAR, 8'h00);
      for (int kind = REQ_DROP + 1; kind <= REQ_TOP; kind++)
         send_request(REQ_W'(kind), 8'hA5);

      // one-byte fixed frames, a zero byte is plain data here
      set_frame_length(1);
      send_request(REQ_RECV, 8'h00);
      send_request(REQ_RECV, 8'hAB);
      send_request(REQ_POP_OLD, 8'h00);
      send_request(REQ_POP_NEW, 8'h00);

      // full store: overflow, then recover and read the whole frame back
      set_frame_length(DEPTH);
      repeat (DEPTH + 2) send_request(REQ_RECV, BYTE_W'($urandom_range(0, 255)));
      send_request(REQ_POP_OLD, 8'h00);
      send_request(REQ_DROP, 8'h00);
      send_request(REQ_POP_NEW, 8'h00);
      random_sent = DEPTH + 29;

      while (random_sent < 150) run_phase($urandom_range(20, 40));

      // closing stretch without idling on either side
      drain();
      idle_on = 1'b0;
      run_phase(40);

      drain();
      if (mirror.faults == 0 && mirror.owed.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/rfb_pkg.sv
rtl/rfb_cell.sv
rtl/rx_frame_buffer.sv
bench/tb_rx_frame_buffer.sv
